// File: src/assert_macros.svh
// Assertion macros used by the line rasterizer back end.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold in the same cycle as the trigger.
`define BRES_ASSERT_IMPL(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// The condition must hold in the cycle after the trigger.
`define BRES_ASSERT_NEXT(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

// File: src/bres_pkg.sv
// Types and constants shared by the line rasterizer modules.
package bres_pkg;

    localparam int IN_W      = 12;
    localparam int COORD_W   = 10;
    localparam int PIX_Y_W   = 9;
    localparam int COLOR_W   = 8;
    localparam int ADDR_W    = 32;
    localparam int ERR_W     = 12;
    localparam int ROW_OFF_W = 20;
    localparam int CMD_DEPTH = 4;
    localparam int CMD_PTR_W = 2;
    localparam int CMD_CNT_W = 3;

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_NEXT  = 1'b1;

    typedef struct packed {
        logic                      action;
        logic signed [IN_W-1:0]    x_start;
        logic signed [IN_W-1:0]    y_start;
        logic signed [IN_W-1:0]    x_end;
        logic signed [IN_W-1:0]    y_end;
        logic        [COLOR_W-1:0] line_color;
    } line_req_t;

    typedef struct packed {
        logic [COORD_W-1:0] pixel_x;
        logic [PIX_Y_W-1:0] pixel_y;
        logic [ADDR_W-1:0]  pixel_address;
        logic [COLOR_W-1:0] write_color;
        logic               last;
    } pixel_t;

    typedef struct packed {
        logic                     is_start;
        logic [COORD_W-1:0]       col;
        logic [COORD_W-1:0]       row;
        logic [ROW_OFF_W-1:0]     row_off;
        logic signed [ERR_W-1:0]  err;
        logic [COORD_W-1:0]       major;
        logic [COORD_W-1:0]       minor;
        logic signed [1:0]        col_step;
        logic signed [1:0]        row_step;
        logic                     swapped;
        logic [COLOR_W-1:0]       color;
    } line_cmd_t;

endpackage

// File: src/bresenham_line_pixel_generator_core.sv
// Top level of the Bresenham line rasterizer: configuration register and unit wiring.
//
// Requests enter through push/full and are taken at an edge where push is high and full
// is low. A request with action start clamps both endpoints to the screen and loads a new
// line, abandoning any unfinished one; it gives no pixel. A request with action next gives
// one pixel of the active line, or nothing when no line is active.
// Pixels leave through empty/pop: the oldest pixel sits on the pixel port while empty is
// low and is taken at an edge where pop is high. The last pixel of a line has last set.
// frame_base is written through cfg_valid/cfg_ready (always ready); the user must write
// it only while the block is idle, which the block does not enforce. The clamp stage
// loads on the accepting edge, setup enters the command queue, and stepping fills the
// output register. Throughput: one request per cycle while full is low; the stepping
// loop does one pixel per cycle while pop is high. When pop stays low the output
// register holds, the four-entry command queue and the clamp stage fill, and full rises.
// Reset clears the line state, the queue and frame_base; no line is active afterward.
module bresenham_line_pixel_generator_core #(
    parameter int SCREEN_WIDTH  = 640,
    parameter int SCREEN_HEIGHT = 480
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  bres_pkg::line_req_t  line_req,
    output logic                 empty,
    input  logic                 pop,
    output bres_pkg::pixel_t     pixel,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [31:0]          cfg_data
);
    import bres_pkg::*;

    logic [ADDR_W-1:0] frame_base_reg;
    logic [ADDR_W-1:0] frame_base_next;

    logic      f_cmd_valid;
    logic      f_cmd_ready;
    line_cmd_t f_cmd;
    logic      q_valid;
    logic      q_pop;
    line_cmd_t q_cmd;

    assign cfg_ready       = 1'b1;
    assign frame_base_next = (cfg_valid && cfg_ready) ? cfg_data : frame_base_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_base_reg <= '0;
        end
        else
        begin
            frame_base_reg <= frame_base_next;
        end
    end

    bres_front #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .line_req  (line_req),
        .cmd_valid (f_cmd_valid),
        .cmd_ready (f_cmd_ready),
        .cmd       (f_cmd)
    );

    bres_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_cmd_valid),
        .wr_ready (f_cmd_ready),
        .wr_data  (f_cmd),
        .rd_valid (q_valid),
        .rd_pop   (q_pop),
        .rd_data  (q_cmd)
    );

    bres_back #(
        .SCREEN_WIDTH (SCREEN_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (q_valid),
        .cmd_pop    (q_pop),
        .cmd        (q_cmd),
        .frame_base (frame_base_reg),
        .empty      (empty),
        .pop        (pop),
        .pixel      (pixel)
    );

endmodule

// File: src/bres_front.sv
// Front end: clamps endpoints, then sets up deltas, steps and error term.
module bres_front #(
    parameter int SCREEN_WIDTH  = 640,
    parameter int SCREEN_HEIGHT = 480
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  bres_pkg::line_req_t  line_req,
    output logic                 cmd_valid,
    input  logic                 cmd_ready,
    output bres_pkg::line_cmd_t  cmd
);
    import bres_pkg::*;

    localparam logic [COORD_W-1:0]   COL_MAX    = COORD_W'(SCREEN_WIDTH - 1);
    localparam logic [COORD_W-1:0]   ROW_MAX    = COORD_W'(SCREEN_HEIGHT - 1);
    localparam logic [ROW_OFF_W-1:0] ROW_STRIDE = ROW_OFF_W'(SCREEN_WIDTH);

    typedef struct packed {
        logic               action;
        logic [COORD_W-1:0] col1;
        logic [COORD_W-1:0] row1;
        logic [COORD_W-1:0] col2;
        logic [COORD_W-1:0] row2;
        logic [COLOR_W-1:0] color;
    } clamped_t;

    function automatic logic [COORD_W-1:0] clamp_coord(
        input logic signed [IN_W-1:0] v,
        input logic [COORD_W-1:0]     hi
    );
        logic [IN_W-2:0] mag;
        mag = v[IN_W-2:0];
        if (v[IN_W-1])
            return '0;
        if (mag > (IN_W-1)'(hi))
            return hi;
        return mag[COORD_W-1:0];
    endfunction

    logic     a_valid_reg;
    logic     a_valid_next;
    clamped_t a_reg;
    logic     a_ready;

    logic [COORD_W-1:0]   dx;
    logic [COORD_W-1:0]   dy;
    logic signed [1:0]    cstep;
    logic signed [1:0]    rstep;
    logic                 swapped;
    logic [COORD_W-1:0]   major;
    logic [COORD_W-1:0]   minor;
    logic [ERR_W:0]       err_wide;
    logic [ROW_OFF_W-1:0] row_off;

    assign a_ready      = !a_valid_reg || cmd_ready;
    assign full         = !a_ready;
    assign a_valid_next = a_ready ? push : a_valid_reg;
    assign cmd_valid    = a_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && push)
        begin
            a_reg.action <= line_req.action;
            a_reg.col1   <= clamp_coord(line_req.x_start, COL_MAX);
            a_reg.row1   <= clamp_coord(line_req.y_start, ROW_MAX);
            a_reg.col2   <= clamp_coord(line_req.x_end, COL_MAX);
            a_reg.row2   <= clamp_coord(line_req.y_end, ROW_MAX);
            a_reg.color  <= line_req.line_color;
        end
    end

    always_comb
    begin
        if (a_reg.col2 < a_reg.col1)
        begin
            dx    = a_reg.col1 - a_reg.col2;
            cstep = -2'sd1;
        end
        else
        begin
            dx    = a_reg.col2 - a_reg.col1;
            cstep = (a_reg.col2 == a_reg.col1) ? 2'sd0 : 2'sd1;
        end
        if (a_reg.row2 < a_reg.row1)
        begin
            dy    = a_reg.row1 - a_reg.row2;
            rstep = -2'sd1;
        end
        else
        begin
            dy    = a_reg.row2 - a_reg.row1;
            rstep = (a_reg.row2 == a_reg.row1) ? 2'sd0 : 2'sd1;
        end
        swapped  = dy > dx;
        major    = swapped ? dy : dx;
        minor    = swapped ? dx : dy;
        err_wide = {2'b00, minor, 1'b0} - {3'b000, major};
        row_off  = ROW_OFF_W'({{(ROW_OFF_W-COORD_W){1'b0}}, a_reg.row1} * ROW_STRIDE);

        cmd.is_start = (a_reg.action == ACT_START);
        cmd.col      = a_reg.col1;
        cmd.row      = a_reg.row1;
        cmd.row_off  = row_off;
        cmd.err      = err_wide[ERR_W-1:0];
        cmd.major    = major;
        cmd.minor    = minor;
        cmd.col_step = cstep;
        cmd.row_step = rstep;
        cmd.swapped  = swapped;
        cmd.color    = a_reg.color;
    end

endmodule

// File: src/bres_cmd_fifo.sv
// Short command queue between the setup front end and the stepping back end.
module bres_cmd_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_valid,
    output logic                 wr_ready,
    input  bres_pkg::line_cmd_t  wr_data,
    output logic                 rd_valid,
    input  logic                 rd_pop,
    output bres_pkg::line_cmd_t  rd_data
);
    import bres_pkg::*;

    line_cmd_t            entries_reg [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] wr_ptr_reg;
    logic [CMD_PTR_W-1:0] wr_ptr_next;
    logic [CMD_PTR_W-1:0] rd_ptr_reg;
    logic [CMD_PTR_W-1:0] rd_ptr_next;
    logic [CMD_CNT_W-1:0] count_reg;
    logic [CMD_CNT_W-1:0] count_next;
    logic                 do_wr;
    logic                 do_rd;

    assign wr_ready = (count_reg != CMD_CNT_W'(CMD_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = entries_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_pop && rd_valid;

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entries_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// File: src/bres_back.sv
// Back end: holds the active line, steps it one pixel per request, drives results.
`include "assert_macros.svh"

module bres_back #(
    parameter int SCREEN_WIDTH = 640
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_pop,
    input  bres_pkg::line_cmd_t  cmd,
    input  logic [31:0]          frame_base,
    output logic                 empty,
    input  logic                 pop,
    output bres_pkg::pixel_t     pixel
);
    import bres_pkg::*;

    localparam logic [ROW_OFF_W-1:0] ROW_STRIDE = ROW_OFF_W'(SCREEN_WIDTH);

    logic                    active_reg;
    logic                    active_next;
    logic [COORD_W-1:0]      col_reg;
    logic [COORD_W-1:0]      col_next;
    logic [COORD_W-1:0]      row_reg;
    logic [COORD_W-1:0]      row_next;
    logic [ROW_OFF_W-1:0]    row_off_reg;
    logic [ROW_OFF_W-1:0]    row_off_next;
    logic signed [ERR_W-1:0] err_reg;
    logic signed [ERR_W-1:0] err_next;
    logic [COORD_W-1:0]      major_reg;
    logic [COORD_W-1:0]      major_next;
    logic [COORD_W-1:0]      minor_reg;
    logic [COORD_W-1:0]      minor_next;
    logic [COORD_W-1:0]      done_reg;
    logic [COORD_W-1:0]      done_next;
    logic signed [1:0]       cstep_reg;
    logic signed [1:0]       cstep_next;
    logic signed [1:0]       rstep_reg;
    logic signed [1:0]       rstep_next;
    logic                    swapped_reg;
    logic                    swapped_next;
    logic [COLOR_W-1:0]      color_reg;
    logic [COLOR_W-1:0]      color_next;

    logic                    out_valid_reg;
    logic                    out_valid_next;
    pixel_t                  out_reg;
    pixel_t                  out_next;

    logic                    out_ready;
    logic                    emit;
    logic                    is_last;
    logic                    err_ge0;
    logic                    col_moves;
    logic                    row_moves;
    logic [ERR_W:0]          err_sum;
    logic [ROW_OFF_W-1:0]    row_off_step;

    assign out_ready = !out_valid_reg || pop;
    assign cmd_pop   = cmd_valid && (cmd.is_start || !active_reg || out_ready);
    assign emit      = cmd_valid && !cmd.is_start && active_reg && out_ready;
    assign is_last   = (done_reg >= major_reg);
    assign err_ge0   = !err_reg[ERR_W-1];
    assign empty     = !out_valid_reg;
    assign pixel     = out_reg;

    always_comb
    begin
        active_next  = active_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        row_off_next = row_off_reg;
        err_next     = err_reg;
        major_next   = major_reg;
        minor_next   = minor_reg;
        done_next    = done_reg;
        cstep_next   = cstep_reg;
        rstep_next   = rstep_reg;
        swapped_next = swapped_reg;
        color_next   = color_reg;

        // The minor axis moves only when the error term is not negative.
        col_moves = !swapped_reg || err_ge0;
        row_moves = swapped_reg || err_ge0;
        err_sum   = {err_reg[ERR_W-1], err_reg} + {2'b00, minor_reg, 1'b0}
                    - (err_ge0 ? {2'b00, major_reg, 1'b0} : '0);
        case (rstep_reg)
            2'sd1:   row_off_step = row_off_reg + ROW_STRIDE;
            -2'sd1:  row_off_step = row_off_reg - ROW_STRIDE;
            default: row_off_step = row_off_reg;
        endcase

        if (cmd_valid && cmd.is_start)
        begin
            active_next  = 1'b1;
            col_next     = cmd.col;
            row_next     = cmd.row;
            row_off_next = cmd.row_off;
            err_next     = cmd.err;
            major_next   = cmd.major;
            minor_next   = cmd.minor;
            done_next    = '0;
            cstep_next   = cmd.col_step;
            rstep_next   = cmd.row_step;
            swapped_next = cmd.swapped;
            color_next   = cmd.color;
        end
        else if (emit)
        begin
            if (is_last)
            begin
                active_next = 1'b0;
            end
            else
            begin
                if (col_moves)
                    col_next = col_reg + {{(COORD_W-2){cstep_reg[1]}}, cstep_reg};
                if (row_moves)
                begin
                    row_next     = row_reg + {{(COORD_W-2){rstep_reg[1]}}, rstep_reg};
                    row_off_next = row_off_step;
                end
                err_next  = err_sum[ERR_W-1:0];
                done_next = done_reg + 1'b1;
            end
        end

        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (out_ready)
        begin
            out_valid_next         = emit;
            out_next.pixel_x       = col_reg;
            out_next.pixel_y       = row_reg[PIX_Y_W-1:0];
            out_next.pixel_address = frame_base + ADDR_W'(row_off_reg) + ADDR_W'(col_reg);
            out_next.write_color   = color_reg;
            out_next.last          = is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
            row_off_reg   <= '0;
            err_reg       <= '0;
            major_reg     <= '0;
            minor_reg     <= '0;
            done_reg      <= '0;
            cstep_reg     <= '0;
            rstep_reg     <= '0;
            swapped_reg   <= 1'b0;
            color_reg     <= '0;
        end
        else
        begin
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            row_off_reg   <= row_off_next;
            err_reg       <= err_next;
            major_reg     <= major_next;
            minor_reg     <= minor_next;
            done_reg      <= done_next;
            cstep_reg     <= cstep_next;
            rstep_reg     <= rstep_next;
            swapped_reg   <= swapped_next;
            color_reg     <= color_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    `BRES_ASSERT_NEXT(a_last_ends_line, emit && is_last, !active_reg, "line still active after last pixel")
    `BRES_ASSERT_IMPL(a_done_bounded, active_reg, done_reg <= major_reg, "pixel count ran past the line length")
    `BRES_ASSERT_NEXT(a_emit_shows, emit, out_valid_reg, "emitted pixel did not reach the output")
    `BRES_ASSERT_NEXT(a_start_loads, cmd_valid && cmd.is_start, active_reg && done_reg == '0, "start request did not load a fresh line")

endmodule

// File: test/bres_line_checker.sv
// Checker for the line rasterizer: predicts every pixel from the accepted requests and compares.
`timescale 1ns / 1ps

module bres_line_checker #(
    parameter int SCREEN_W = 640,
    parameter int SCREEN_H = 480
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic                full,
    input  bres_pkg::line_req_t line_req,
    input  logic                empty,
    input  logic                pop,
    input  bres_pkg::pixel_t    pixel,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [31:0]         cfg_data,
    output int                  mismatches,
    output int                  waiting
);
    import bres_pkg::*;

    // Predicted line state.
    logic [31:0] base_addr;
    bit          drawing;
    int          col;
    int          row;
    int          err;
    int          major;
    int          minor;
    int          steps_done;
    int          col_dir;
    int          row_dir;
    bit          steep;
    logic [7:0]  color;

    pixel_t expected_pixels[$];

    function automatic int clamp_coord(int v, int hi);
        if (v < 0)
            return 0;
        if (v > hi)
            return hi;
        return v;
    endfunction

    task automatic rasterize_request(line_req_t r);
        int     x1;
        int     y1;
        int     x2;
        int     y2;
        int     dx;
        int     dy;
        pixel_t p;
        if (r.action == ACT_START)
        begin
            x1 = clamp_coord(int'(r.x_start), SCREEN_W - 1);
            y1 = clamp_coord(int'(r.y_start), SCREEN_H - 1);
            x2 = clamp_coord(int'(r.x_end), SCREEN_W - 1);
            y2 = clamp_coord(int'(r.y_end), SCREEN_H - 1);
            if (x2 < x1)
            begin
                dx = x1 - x2;
                col_dir = -1;
            end
            else
            begin
                dx = x2 - x1;
                col_dir = (x2 == x1) ? 0 : 1;
            end
            if (y2 < y1)
            begin
                dy = y1 - y2;
                row_dir = -1;
            end
            else
            begin
                dy = y2 - y1;
                row_dir = (y2 == y1) ? 0 : 1;
            end
            steep = dy > dx;
            major = steep ? dy : dx;
            minor = steep ? dx : dy;
            err = 2 * minor - major;
            col = x1;
            row = y1;
            steps_done = 0;
            color = r.line_color;
            drawing = 1'b1;
        end
        else if (drawing)
        begin
            p.pixel_x = col[COORD_W-1:0];
            p.pixel_y = row[PIX_Y_W-1:0];
            p.pixel_address = base_addr + 32'(row * SCREEN_W) + 32'(col);
            p.write_color = color;
            p.last = steps_done >= major;
            expected_pixels.push_back(p);
            if (p.last)
                drawing = 1'b0;
            else
            begin
                if (err >= 0)
                begin
                    if (steep)
                        col += col_dir;
                    else
                        row += row_dir;
                    err -= 2 * major;
                end
                if (steep)
                    row += row_dir;
                else
                    col += col_dir;
                err += 2 * minor;
                steps_done++;
            end
        end
    endtask

    task automatic compare_field(string name, longint unsigned want, longint unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pixel_t want;
        if (!rst_n)
        begin
            base_addr = '0;
            drawing = 1'b0;
            col = 0;
            row = 0;
            err = 0;
            major = 0;
            minor = 0;
            steps_done = 0;
            col_dir = 0;
            row_dir = 0;
            steep = 1'b0;
            color = '0;
            expected_pixels.delete();
            mismatches = 0;
            waiting = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $error("pixel (%0d,%0d) arrived with none expected",
                           pixel.pixel_x, pixel.pixel_y);
                    mismatches++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    compare_field("pixel_x", want.pixel_x, pixel.pixel_x);
                    compare_field("pixel_y", want.pixel_y, pixel.pixel_y);
                    compare_field("pixel_address", want.pixel_address, pixel.pixel_address);
                    compare_field("write_color", want.write_color, pixel.write_color);
                    compare_field("last", want.last, pixel.last);
                end
            end
            if (push && !full)
                rasterize_request(line_req);
            if (cfg_valid && cfg_ready)
                base_addr = cfg_data;
            waiting = expected_pixels.size();
        end
    end

endmodule

// File: test/tb.sv
// Testbench top for the line rasterizer: clock, reset, request and register stimulus, verdict.
`timescale 1ns / 1ps

module tb;
    import bres_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int ITEMS_PER_PHASE = 100;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    line_req_t   line_req;
    logic        empty;
    logic        pop;
    pixel_t      pixel;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;

    int mismatches;
    int waiting;
    int cycle_count;
    int idle_pct;
    int stall_pct;
    bit push_taken;
    bit cfg_taken;

    bresenham_line_pixel_generator_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .line_req  (line_req),
        .empty     (empty),
        .pop       (pop),
        .pixel     (pixel),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    bres_line_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .line_req   (line_req),
        .empty      (empty),
        .pop        (pop),
        .pixel      (pixel),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .waiting    (waiting)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Handshake results are captured at the edge and read back at the following falling edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push_taken <= 1'b0;
            cfg_taken <= 1'b0;
        end
        else
        begin
            push_taken <= push && !full;
            cfg_taken <= cfg_valid && cfg_ready;
        end
    end

    // The pixel side stalls on its own, independent of the request side.
    initial
    begin
        pop = 1'b0;
        forever
        begin
            @(negedge clk);
            pop <= (int'($urandom_range(99)) >= stall_pct);
        end
    end

    function automatic int clip(int v, int hi);
        return (v < 0) ? 0 : ((v > hi) ? hi : v);
    endfunction

    function automatic int line_pixels(int x1, int y1, int x2, int y2);
        int dx;
        int dy;
        dx = clip(x2, 639) - clip(x1, 639);
        dy = clip(y2, 479) - clip(y1, 479);
        dx = (dx < 0) ? -dx : dx;
        dy = (dy < 0) ? -dy : dy;
        return ((dx > dy) ? dx : dy) + 1;
    endfunction

    task automatic send_req(line_req_t r);
        while (int'($urandom_range(99)) < idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push <= 1'b1;
        line_req <= r;
        do
            @(negedge clk);
        while (!push_taken);
    endtask

    task automatic send_next();
        line_req_t r;
        r = line_req_t'({$urandom, $urandom});
        r.action = ACT_NEXT;
        send_req(r);
    endtask

    task automatic draw_line(int x1, int y1, int x2, int y2, logic [7:0] c, int nexts);
        line_req_t r;
        r.action = ACT_START;
        r.x_start = x1[IN_W-1:0];
        r.y_start = y1[IN_W-1:0];
        r.x_end = x2[IN_W-1:0];
        r.y_end = y2[IN_W-1:0];
        r.line_color = c;
        send_req(r);
        repeat (nexts)
            send_next();
    endtask

    // Drain the pixels, let any request still in the pipe settle, then write frame_base.
    task automatic write_base(logic [31:0] value);
        push <= 1'b0;
        while (waiting != 0)
            @(negedge clk);
        repeat (10)
            @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(negedge clk);
        while (!cfg_taken);
        cfg_valid <= 1'b0;
    endtask

    function automatic int extreme_coord();
        case ($urandom_range(7))
            0: return -2048;
            1: return -1;
            2: return 0;
            3: return 639;
            4: return 640;
            5: return 479;
            6: return 480;
            default: return 2047;
        endcase
    endfunction

    task automatic random_sequence(inout int count);
        int x1;
        int y1;
        int x2;
        int y2;
        int len;
        int nexts;
        int pick;
        int kind;
        pick = $urandom_range(99);
        if (pick < 85)
        begin
            kind = $urandom_range(99);
            if (kind < 85)
            begin
                // Short lines near a random point keep most lines complete.
                x1 = $urandom_range(639);
                y1 = $urandom_range(479);
                x2 = x1 + int'($urandom_range(24)) - 12;
                y2 = y1 + int'($urandom_range(24)) - 12;
            end
            else if (kind < 95)
            begin
                x1 = int'($urandom_range(4095)) - 2048;
                y1 = int'($urandom_range(4095)) - 2048;
                x2 = int'($urandom_range(4095)) - 2048;
                y2 = int'($urandom_range(4095)) - 2048;
            end
            else
            begin
                x1 = extreme_coord();
                y1 = extreme_coord();
                x2 = extreme_coord();
                y2 = extreme_coord();
            end
            len = line_pixels(x1, y1, x2, y2);
            // Long lines are mostly cut short so that the request count stays near the budget.
            if (len > 30 && $urandom_range(15) != 0)
                nexts = $urandom_range(1, 20);
            else if ($urandom_range(9) == 0)
                nexts = $urandom_range(len - 1);
            else
                nexts = len;
            draw_line(x1, y1, x2, y2, 8'($urandom), nexts);
            count += 1 + nexts;
        end
        else if (pick < 95)
        begin
            // Stray next requests, mostly while no line is active.
            repeat ($urandom_range(1, 3))
                send_next();
        end
        else
        begin
            // A start that is replaced right away.
            draw_line(int'($urandom_range(4095)) - 2048, int'($urandom_range(4095)) - 2048,
                      int'($urandom_range(4095)) - 2048, int'($urandom_range(4095)) - 2048,
                      8'($urandom), 0);
            count++;
        end
    endtask

    task automatic directed_lines();
        send_next();
        draw_line(-2048, -2048, 2047, 2047, 8'hff, 3);
        draw_line(5, 5, 5, 5, 8'h00, 2);
        draw_line(-2048, 2047, -1, 600, 8'h5a, 1);
        draw_line(10, 20, 8, 14, 8'ha5, 7);
        draw_line(639, 0, 636, 0, 8'h3c, 4);
    endtask

    initial
    begin
        logic [31:0] bases[8];
        int          count;
        rst_n = 1'b0;
        push = 1'b0;
        line_req = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        idle_pct = 0;
        stall_pct = 0;
        bases = '{32'hffff_ffff, 32'h0, $urandom, 32'h8000_0000,
                  $urandom, 32'h0, 32'hffff_f000, $urandom};
        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        for (int ph = 0; ph < 8; ph++)
        begin
            write_base(bases[ph]);
            case (ph % 4)
                0:
                begin
                    idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct = 65;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct = 0;
                    stall_pct = 65;
                end
                default:
                begin
                    idle_pct = 24;
                    stall_pct = 24;
                end
            endcase
            if (ph == 0)
                directed_lines();
            count = 0;
            while (count < ITEMS_PER_PHASE)
                random_sequence(count);
        end
        push <= 1'b0;
        stall_pct = 0;
        while (waiting != 0)
            @(negedge clk);
        repeat (20)
            @(negedge clk);
        if (waiting != 0)
            $error("%0d expected pixels never arrived", waiting);
        if (mismatches == 0 && waiting == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+src
src/bres_pkg.sv
src/bres_front.sv
src/bres_cmd_fifo.sv
src/bres_back.sv
src/bresenham_line_pixel_generator_core.sv
test/bres_line_checker.sv
test/tb.sv
